// File: hdl/xor_popcount_walsh_chain_stats_defines.svh
// Assertion macros shared by the RTL of the XOR popcount Walsh statistics block.
`ifndef XOR_POPCOUNT_WALSH_CHAIN_STATS_DEFINES_SVH
`define XOR_POPCOUNT_WALSH_CHAIN_STATS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on aclk and quiet during reset.
`define XPCS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("xpcs assertion failed");

// Next-cycle implication, sampled on aclk and quiet during reset.
`define XPCS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("xpcs assertion failed");

`else

`define XPCS_ASSERT_IMP(name, ante, cons)
`define XPCS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: hdl/xpcs_pkg.sv
// Shared types, constants and popcount helpers for the XOR popcount Walsh statistics block.
`default_nettype none

package xpcs_pkg;

    // Correlation and popcount limit: 64 samples per word times 2048 words.
    localparam int CORR_LIMIT = 131072;
    localparam int SAMPLE_COUNT_RESET = 131072;

    // Tuple queue between the front and the back.
    localparam int QUEUE_AW = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef logic [7:0][3:0] byte_cnt_t;

    // One closed tuple: the two popcount totals and the four column indices.
    typedef struct packed {
        logic [17:0] pop_in;
        logic [17:0] pop_out;
        logic [7:0]  idx_fourth;
        logic [7:0]  idx_third;
        logic [7:0]  idx_second;
        logic [7:0]  idx_first;
    } tuple_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [3:0] pop8(logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, b[i]};
        end
        return n;
    endfunction

    function automatic byte_cnt_t byte_counts(logic [63:0] w);
        byte_cnt_t c;
        for (int i = 0; i < 8; i++) begin
            c[i] = pop8(w[8*i +: 8]);
        end
        return c;
    endfunction

    function automatic logic [6:0] sum_bytes(byte_cnt_t c);
        logic [6:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, c[i]};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hdl/xpcs_front.sv
// Front end: XOR of the four columns, popcount against both masks, per-tuple accumulation.
`default_nettype none

module xpcs_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [63:0]          s_col_a_word,
    input  wire logic [63:0]          s_col_b_word,
    input  wire logic [63:0]          s_col_c_word,
    input  wire logic [63:0]          s_col_d_word,
    input  wire logic [63:0]          s_in_mask_word,
    input  wire logic [63:0]          s_out_mask_word,
    input  wire logic [7:0]           s_first_index,
    input  wire logic [7:0]           s_second_index,
    input  wire logic [7:0]           s_third_index,
    input  wire logic [7:0]           s_fourth_index,
    input  wire logic                 s_last_word,
    input  wire xpcs_pkg::queue_stat_t q_stat,
    output logic                      q_push,
    output xpcs_pkg::tuple_t          q_wdata
);

    logic                  f_valid_reg;
    logic                  f_valid_next;
    logic                  f_last_reg;
    xpcs_pkg::byte_cnt_t   cnt_in_reg;
    xpcs_pkg::byte_cnt_t   cnt_out_reg;
    logic [31:0]           idx_reg;
    logic [17:0]           acc_in_reg;
    logic [17:0]           acc_in_next;
    logic [17:0]           acc_out_reg;
    logic [17:0]           acc_out_next;
    logic [63:0]           x_word;
    logic                  take;
    logic                  consume;
    logic [18:0]           sum_in;
    logic [18:0]           sum_out;
    logic [17:0]           sat_in;
    logic [17:0]           sat_out;

    // The staged word leaves unless it closes a tuple and the queue has no room.
    assign s_ready = !f_valid_reg || !f_last_reg || !q_stat.full;
    assign take    = s_valid && s_ready;
    assign consume = f_valid_reg && s_ready;
    assign x_word  = s_col_a_word ^ s_col_b_word ^ s_col_c_word ^ s_col_d_word;

    always_comb begin
        sum_in  = {1'b0, acc_in_reg} + 19'(xpcs_pkg::sum_bytes(cnt_in_reg));
        sum_out = {1'b0, acc_out_reg} + 19'(xpcs_pkg::sum_bytes(cnt_out_reg));
        sat_in  = (sum_in > 19'(xpcs_pkg::CORR_LIMIT)) ? 18'(xpcs_pkg::CORR_LIMIT)
                                                        : sum_in[17:0];
        sat_out = (sum_out > 19'(xpcs_pkg::CORR_LIMIT)) ? 18'(xpcs_pkg::CORR_LIMIT)
                                                         : sum_out[17:0];
        acc_in_next  = acc_in_reg;
        acc_out_next = acc_out_reg;
        if (consume) begin
            acc_in_next  = f_last_reg ? '0 : sat_in;
            acc_out_next = f_last_reg ? '0 : sat_out;
        end
        f_valid_next = s_ready ? take : f_valid_reg;
    end

    assign q_push            = consume && f_last_reg;
    assign q_wdata.pop_in    = sat_in;
    assign q_wdata.pop_out   = sat_out;
    assign q_wdata.idx_first  = idx_reg[7:0];
    assign q_wdata.idx_second = idx_reg[15:8];
    assign q_wdata.idx_third  = idx_reg[23:16];
    assign q_wdata.idx_fourth = idx_reg[31:24];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            acc_in_reg  <= '0;
            acc_out_reg <= '0;
        end else begin
            f_valid_reg <= f_valid_next;
            acc_in_reg  <= acc_in_next;
            acc_out_reg <= acc_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_last_reg  <= s_last_word;
            cnt_in_reg  <= xpcs_pkg::byte_counts(x_word ^ s_in_mask_word);
            cnt_out_reg <= xpcs_pkg::byte_counts(x_word ^ s_out_mask_word);
            idx_reg     <= {s_fourth_index, s_third_index, s_second_index, s_first_index};
        end
    end

endmodule

`default_nettype wire

// File: hdl/xpcs_queue.sv
// Short tuple queue between the front end and the statistics back end.
`default_nettype none

module xpcs_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire xpcs_pkg::tuple_t      wdata,
    input  wire logic                  pop,
    output xpcs_pkg::tuple_t           rdata,
    output xpcs_pkg::queue_stat_t      stat
);

    xpcs_pkg::tuple_t                 entry_reg [xpcs_pkg::QUEUE_DEPTH];
    logic [xpcs_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [xpcs_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [xpcs_pkg::QUEUE_AW:0]      count_reg;
    logic [xpcs_pkg::QUEUE_AW:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign stat.full  = (count_reg == (xpcs_pkg::QUEUE_AW + 1)'(xpcs_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: hdl/xpcs_back.sv
// Back end: correlations, products, thresholds and the running statistics.
`default_nettype none

module xpcs_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [17:0]           sample_count,
    input  wire xpcs_pkg::tuple_t      q_rdata,
    input  wire xpcs_pkg::queue_stat_t q_stat,
    output logic                       q_pop,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [63:0]         m_product_total,
    output logic [17:0]                m_peak_abs_in,
    output logic [17:0]                m_peak_abs_out,
    output logic [7:0]                 m_best_first,
    output logic [7:0]                 m_best_second,
    output logic [7:0]                 m_best_third,
    output logic [7:0]                 m_best_fourth,
    output logic signed [18:0]         m_best_corr_in,
    output logic signed [18:0]         m_best_corr_out,
    output logic [31:0]                m_both_over_two,
    output logic [31:0]                m_both_over_three,
    output logic [31:0]                m_tuple_total
);

    function automatic logic signed [18:0] corr(logic [17:0] n, logic [17:0] pop);
        logic signed [19:0] c;
        c = $signed({2'b00, n}) - $signed({1'b0, pop, 1'b0});
        if (c > 20'sd131072) begin
            return 19'(xpcs_pkg::CORR_LIMIT);
        end else if (c < -20'sd131072) begin
            return 19'(-xpcs_pkg::CORR_LIMIT);
        end
        return c[18:0];
    endfunction

    function automatic logic [17:0] mag(logic signed [18:0] c);
        logic [18:0] neg;
        neg = 19'(-c);
        return c[18] ? neg[17:0] : c[17:0];
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    logic                 en;
    logic                 m_valid_reg;

    // Stage 1: correlations.
    logic                 b1_valid_reg;
    logic signed [18:0]   b1_ci_reg;
    logic signed [18:0]   b1_co_reg;
    logic [17:0]          b1_ai_reg;
    logic [17:0]          b1_ao_reg;
    logic [31:0]          b1_idx_reg;
    logic signed [18:0]   ci;
    logic signed [18:0]   co;

    // Stage 2: products.
    logic                 b2_valid_reg;
    logic signed [37:0]   b2_prod_reg;
    logic [34:0]          b2_ap_reg;
    logic [34:0]          b2_ai2_reg;
    logic [34:0]          b2_ao2_reg;
    logic signed [18:0]   b2_ci_reg;
    logic signed [18:0]   b2_co_reg;
    logic [17:0]          b2_ai_reg;
    logic [17:0]          b2_ao_reg;
    logic [31:0]          b2_idx_reg;
    logic signed [37:0]   prod_w;
    logic [35:0]          ap_w;
    logic [35:0]          ai2_w;
    logic [35:0]          ao2_w;

    // Running statistics, also the result register.
    logic [63:0]          sum_reg;
    logic [17:0]          peak_in_reg;
    logic [17:0]          peak_out_reg;
    logic [34:0]          peak_prod_reg;
    logic [31:0]          best_idx_reg;
    logic signed [18:0]   best_ci_reg;
    logic signed [18:0]   best_co_reg;
    logic [31:0]          over_two_reg;
    logic [31:0]          over_three_reg;
    logic [31:0]          tuple_reg;
    logic [34:0]          thr_two;
    logic [34:0]          thr_three;
    logic                 hit_two;
    logic                 hit_three;
    logic                 update;

    // The whole back end moves together whenever the result slot is free or being taken.
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_stat.empty;

    assign ci = corr(sample_count, q_rdata.pop_in);
    assign co = corr(sample_count, q_rdata.pop_out);

    assign prod_w = b1_ci_reg * b1_co_reg;
    assign ap_w   = b1_ai_reg * b1_ao_reg;
    assign ai2_w  = b1_ai_reg * b1_ai_reg;
    assign ao2_w  = b1_ao_reg * b1_ao_reg;

    assign thr_two   = {15'd0, sample_count, 2'b00};
    assign thr_three = {13'd0, ({1'b0, sample_count, 3'b000} + {4'b0000, sample_count})};
    assign hit_two   = (b2_ai2_reg > thr_two) && (b2_ao2_reg > thr_two);
    assign hit_three = (b2_ai2_reg > thr_three) && (b2_ao2_reg > thr_three);
    assign update    = en && b2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg   <= 1'b0;
            b2_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            sum_reg        <= '0;
            peak_in_reg    <= '0;
            peak_out_reg   <= '0;
            peak_prod_reg  <= '0;
            best_idx_reg   <= '0;
            best_ci_reg    <= '0;
            best_co_reg    <= '0;
            over_two_reg   <= '0;
            over_three_reg <= '0;
            tuple_reg      <= '0;
        end else begin
            if (en) begin
                b1_valid_reg <= !q_stat.empty;
                b2_valid_reg <= b1_valid_reg;
                m_valid_reg  <= b2_valid_reg;
            end
            if (update) begin
                sum_reg   <= sum_reg + 64'({{26{b2_prod_reg[37]}}, b2_prod_reg});
                tuple_reg <= sat_inc(tuple_reg);
                if (b2_ai_reg > peak_in_reg) begin
                    peak_in_reg <= b2_ai_reg;
                end
                if (b2_ao_reg > peak_out_reg) begin
                    peak_out_reg <= b2_ao_reg;
                end
                if (hit_two) begin
                    over_two_reg <= sat_inc(over_two_reg);
                end
                if (hit_three) begin
                    over_three_reg <= sat_inc(over_three_reg);
                end
                if (b2_ap_reg > peak_prod_reg) begin
                    peak_prod_reg <= b2_ap_reg;
                    best_idx_reg  <= b2_idx_reg;
                    best_ci_reg   <= b2_ci_reg;
                    best_co_reg   <= b2_co_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_ci_reg  <= ci;
            b1_co_reg  <= co;
            b1_ai_reg  <= mag(ci);
            b1_ao_reg  <= mag(co);
            b1_idx_reg <= {q_rdata.idx_fourth, q_rdata.idx_third,
                           q_rdata.idx_second, q_rdata.idx_first};
            b2_prod_reg <= prod_w;
            b2_ap_reg   <= ap_w[34:0];
            b2_ai2_reg  <= ai2_w[34:0];
            b2_ao2_reg  <= ao2_w[34:0];
            b2_ci_reg   <= b1_ci_reg;
            b2_co_reg   <= b1_co_reg;
            b2_ai_reg   <= b1_ai_reg;
            b2_ao_reg   <= b1_ao_reg;
            b2_idx_reg  <= b1_idx_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_product_total   = $signed(sum_reg);
    assign m_peak_abs_in     = peak_in_reg;
    assign m_peak_abs_out    = peak_out_reg;
    assign m_best_first      = best_idx_reg[7:0];
    assign m_best_second     = best_idx_reg[15:8];
    assign m_best_third      = best_idx_reg[23:16];
    assign m_best_fourth     = best_idx_reg[31:24];
    assign m_best_corr_in    = best_ci_reg;
    assign m_best_corr_out   = best_co_reg;
    assign m_both_over_two   = over_two_reg;
    assign m_both_over_three = over_three_reg;
    assign m_tuple_total     = tuple_reg;

endmodule

`default_nettype wire

// File: hdl/xor_popcount_walsh_chain_stats.sv
// Top level of the XOR popcount Walsh correlation statistics block.
//
//   Channel   Direction  Handshake              Moves
//   s_*       in         s_valid / s_ready      one 64-sample word request
//   m_*       out        m_valid / m_ready      one result request per closed tuple
//   cfg_*     in         cfg_valid / cfg_ready  sample count write request
//
// A word request is taken every cycle while s_ready is high. The front holds one
// popcount stage and the back two arithmetic stages ahead of the result register, and
// all of them overlap freely. Reset is synchronous on aresetn low and sets the sample
// count to 131072 with all statistics zero. A stalled result stops only the back end;
// the front keeps accepting words until a word that closes a tuple finds the
// four-entry tuple queue full.
`default_nettype none

`include "xor_popcount_walsh_chain_stats_defines.svh"

module xor_popcount_walsh_chain_stats (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration write channel.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [17:0]        cfg_data,
    // Word requests.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [63:0]        s_col_a_word,
    input  wire logic [63:0]        s_col_b_word,
    input  wire logic [63:0]        s_col_c_word,
    input  wire logic [63:0]        s_col_d_word,
    input  wire logic [63:0]        s_in_mask_word,
    input  wire logic [63:0]        s_out_mask_word,
    input  wire logic [7:0]         s_first_index,
    input  wire logic [7:0]         s_second_index,
    input  wire logic [7:0]         s_third_index,
    input  wire logic [7:0]         s_fourth_index,
    input  wire logic               s_last_word,
    // Result requests.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_product_total,
    output logic [17:0]             m_peak_abs_in,
    output logic [17:0]             m_peak_abs_out,
    output logic [7:0]              m_best_first,
    output logic [7:0]              m_best_second,
    output logic [7:0]              m_best_third,
    output logic [7:0]              m_best_fourth,
    output logic signed [18:0]      m_best_corr_in,
    output logic signed [18:0]      m_best_corr_out,
    output logic [31:0]             m_both_over_two,
    output logic [31:0]             m_both_over_three,
    output logic [31:0]             m_tuple_total
);

    // The sample count N sets the correlation offset and the z thresholds and is never
    // staged. Software must write it only while no tuple is in flight, unchecked here.
    logic [17:0]            sample_count_reg;

    // Closed tuples travel from the front to the back through a short queue.
    xpcs_pkg::tuple_t       q_wdata;
    xpcs_pkg::tuple_t       q_rdata;
    xpcs_pkg::queue_stat_t  q_stat;
    logic                   q_push;
    logic                   q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= 18'(xpcs_pkg::SAMPLE_COUNT_RESET);
        end else if (cfg_valid) begin
            sample_count_reg <= cfg_data;
        end
    end

    // Front: XORs the four columns, counts disagreements with each mask and
    // accumulates both counts until the last word closes the tuple.
    xpcs_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_col_a_word    (s_col_a_word),
        .s_col_b_word    (s_col_b_word),
        .s_col_c_word    (s_col_c_word),
        .s_col_d_word    (s_col_d_word),
        .s_in_mask_word  (s_in_mask_word),
        .s_out_mask_word (s_out_mask_word),
        .s_first_index   (s_first_index),
        .s_second_index  (s_second_index),
        .s_third_index   (s_third_index),
        .s_fourth_index  (s_fourth_index),
        .s_last_word     (s_last_word),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    xpcs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    // Back: forms the clamped correlations, the products and threshold tests in
    // two stages, then folds them into the running statistics, which double as
    // the result register.
    xpcs_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .sample_count      (sample_count_reg),
        .q_rdata           (q_rdata),
        .q_stat            (q_stat),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_product_total   (m_product_total),
        .m_peak_abs_in     (m_peak_abs_in),
        .m_peak_abs_out    (m_peak_abs_out),
        .m_best_first      (m_best_first),
        .m_best_second     (m_best_second),
        .m_best_third      (m_best_third),
        .m_best_fourth     (m_best_fourth),
        .m_best_corr_in    (m_best_corr_in),
        .m_best_corr_out   (m_best_corr_out),
        .m_both_over_two   (m_both_over_two),
        .m_both_over_three (m_both_over_three),
        .m_tuple_total     (m_tuple_total)
    );

    // The front only ever stalls on a full tuple queue.
    `XPCS_ASSERT_IMP(a_stall_on_full, !s_ready, q_stat.full)

    // A tuple over the 3 sigma test also passed the 2 sigma test.
    `XPCS_ASSERT_IMP(a_three_le_two, m_valid, m_both_over_three <= m_both_over_two)

    // Every counted tuple is also in the tuple total.
    `XPCS_ASSERT_IMP(a_two_le_total, m_valid, m_both_over_two <= m_tuple_total)

    // Consecutive results differ by exactly one tuple until the counter saturates.
    `XPCS_ASSERT_NEXT(a_total_steps,
        m_valid && m_ready && (m_tuple_total != 32'hFFFF_FFFF),
        !m_valid || (m_tuple_total == $past(m_tuple_total) + 32'd1))

endmodule

`default_nettype wire

// File: tb/xor_popcount_walsh_chain_stats_tb.sv
// Self-checking testbench for the XOR popcount Walsh correlation statistics block.
`default_nettype none

module xor_popcount_walsh_chain_stats_tb;

    // Run length and pacing.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS = 96;
    localparam int PRESSURE_TUPLES = 24;
    // Fully disagreeing words that bring both correlations to zero at the reset
    // sample count.
    localparam int RESET_CHECK_WORDS = xpcs_pkg::CORR_LIMIT / 128;

    // How the disagreement pattern of a random tuple leans against its masks.
    typedef enum int {
        LEAN_NONE,
        LEAN_AGREE,
        LEAN_OPPOSE
    } lean_t;

    // One word request as it is driven onto the s_ ports.
    typedef struct {
        logic [63:0] col_a;
        logic [63:0] col_b;
        logic [63:0] col_c;
        logic [63:0] col_d;
        logic [63:0] in_mask;
        logic [63:0] out_mask;
        logic [31:0] idx;       // fourth index in the high byte, first in the low byte
        logic        closes;
    } word_req_t;

    // One result request as it should appear on the m_ ports.
    typedef struct {
        logic [63:0] product_total;
        logic [17:0] peak_in;
        logic [17:0] peak_out;
        logic [31:0] best_idx;
        logic [18:0] corr_in;
        logic [18:0] corr_out;
        logic [31:0] over_two;
        logic [31:0] over_three;
        logic [31:0] tuples;
    } stats_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [17:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_col_a_word = '0;
    logic [63:0] s_col_b_word = '0;
    logic [63:0] s_col_c_word = '0;
    logic [63:0] s_col_d_word = '0;
    logic [63:0] s_in_mask_word = '0;
    logic [63:0] s_out_mask_word = '0;
    logic [7:0]  s_first_index = '0;
    logic [7:0]  s_second_index = '0;
    logic [7:0]  s_third_index = '0;
    logic [7:0]  s_fourth_index = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [63:0] m_product_total;
    logic [17:0] m_peak_abs_in;
    logic [17:0] m_peak_abs_out;
    logic [7:0]  m_best_first;
    logic [7:0]  m_best_second;
    logic [7:0]  m_best_third;
    logic [7:0]  m_best_fourth;
    logic signed [18:0] m_best_corr_in;
    logic signed [18:0] m_best_corr_out;
    logic [31:0] m_both_over_two;
    logic [31:0] m_both_over_three;
    logic [31:0] m_tuple_total;

    // Receiver pacing: random stalls while sink_jitter is set, and a long
    // hold-off window while hold_active is set by its own counting process.
    logic        sink_jitter = 1'b0;
    logic        hold_active = 1'b0;
    int unsigned sink_wait = 0;
    event        hold_kick;

    // Our own copy of the block's state, kept at the block's widths.
    logic [17:0] n_samples = 18'(xpcs_pkg::SAMPLE_COUNT_RESET);
    logic [17:0] pop_in_run = '0;
    logic [17:0] pop_out_run = '0;
    logic [63:0] corr_sum = '0;
    logic [17:0] top_in = '0;
    logic [17:0] top_out = '0;
    logic [34:0] top_mag = '0;
    logic [31:0] top_idx = '0;
    logic [18:0] top_ci = '0;
    logic [18:0] top_co = '0;
    logic [31:0] n_two = '0;
    logic [31:0] n_three = '0;
    logic [31:0] n_tuples = '0;

    // Results still owed by the block, oldest first.
    stats_t stats_due[$];

    int errors = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;

    xor_popcount_walsh_chain_stats u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_col_a_word      (s_col_a_word),
        .s_col_b_word      (s_col_b_word),
        .s_col_c_word      (s_col_c_word),
        .s_col_d_word      (s_col_d_word),
        .s_in_mask_word    (s_in_mask_word),
        .s_out_mask_word   (s_out_mask_word),
        .s_first_index     (s_first_index),
        .s_second_index    (s_second_index),
        .s_third_index     (s_third_index),
        .s_fourth_index    (s_fourth_index),
        .s_last_word       (s_last_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_product_total   (m_product_total),
        .m_peak_abs_in     (m_peak_abs_in),
        .m_peak_abs_out    (m_peak_abs_out),
        .m_best_first      (m_best_first),
        .m_best_second     (m_best_second),
        .m_best_third      (m_best_third),
        .m_best_fourth     (m_best_fourth),
        .m_best_corr_in    (m_best_corr_in),
        .m_best_corr_out   (m_best_corr_out),
        .m_both_over_two   (m_both_over_two),
        .m_both_over_three (m_both_over_three),
        .m_tuple_total     (m_tuple_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // A word whose k lowest bits are set.
    function automatic logic [63:0] low_ones(input int k);
        return (k >= 64) ? '1 : (64'd1 << k) - 64'd1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A disagreement pattern with the given lean. About one word in ten is a
    // stray random word so that tuples are not perfectly uniform.
    function automatic logic [63:0] lean_diff(input lean_t lean);
        logic [63:0] sparse;
        sparse = rnd64() & rnd64() & rnd64();
        if ($urandom_range(0, 9) == 0) return rnd64();
        case (lean)
            LEAN_AGREE: return sparse;
            LEAN_OPPOSE: return ~sparse;
            default: return rnd64();
        endcase
    endfunction

    function automatic logic [17:0] add_capped(input logic [17:0] acc, input int n);
        int t;
        t = int'(acc) + n;
        return (t > xpcs_pkg::CORR_LIMIT) ? 18'(xpcs_pkg::CORR_LIMIT) : 18'(t);
    endfunction

    // Correlation N - 2*pop, clamped to the range that 2048 words can reach.
    function automatic longint corr_from_pop(input logic [17:0] pop);
        longint c;
        c = longint'(n_samples) - 2 * longint'(pop);
        if (c > xpcs_pkg::CORR_LIMIT) c = xpcs_pkg::CORR_LIMIT;
        if (c < -xpcs_pkg::CORR_LIMIT) c = -xpcs_pkg::CORR_LIMIT;
        return c;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    // Folds one accepted word into the running statistics. A word that closes
    // its tuple queues the result request the block owes for it.
    task automatic advance_walsh_stats(input word_req_t w);
        logic [63:0] folded;
        longint ci;
        longint co;
        longint ai;
        longint ao;
        longint nn;
        stats_t s;
        folded = w.col_a ^ w.col_b ^ w.col_c ^ w.col_d;
        pop_in_run = add_capped(pop_in_run, $countones(folded ^ w.in_mask));
        pop_out_run = add_capped(pop_out_run, $countones(folded ^ w.out_mask));
        if (!w.closes) return;

        ci = corr_from_pop(pop_in_run);
        co = corr_from_pop(pop_out_run);
        pop_in_run = '0;
        pop_out_run = '0;
        ai = (ci < 0) ? -ci : ci;
        ao = (co < 0) ? -co : co;
        nn = longint'(n_samples);

        corr_sum = corr_sum + 64'(ci * co);
        n_tuples = bump(n_tuples);
        if (ai > top_in) top_in = 18'(ai);
        if (ao > top_out) top_out = 18'(ao);
        // |z| > 2 and |z| > 3 without a square root: c*c against 4N and 9N.
        if (ai * ai > 4 * nn && ao * ao > 4 * nn) n_two = bump(n_two);
        if (ai * ai > 9 * nn && ao * ao > 9 * nn) n_three = bump(n_three);
        // Only a strictly larger product replaces the best tuple, so ties keep
        // the earlier one and zero products never set it.
        if (ai * ao > top_mag) begin
            top_mag = 35'(ai * ao);
            top_idx = w.idx;
            top_ci = 19'(ci);
            top_co = 19'(co);
        end

        s.product_total = corr_sum;
        s.peak_in = top_in;
        s.peak_out = top_out;
        s.best_idx = top_idx;
        s.corr_in = top_ci;
        s.corr_out = top_co;
        s.over_two = n_two;
        s.over_three = n_three;
        s.tuples = n_tuples;
        stats_due.push_back(s);
    endtask

    // Builds a word whose column XOR differs from the input and output masks in
    // exactly the given bits, offers it, waits for the request to be taken and
    // then updates the prediction. Valid stays high into the next call when no
    // gap is drawn.
    task automatic send_word(input logic [63:0] in_diff, input logic [63:0] out_diff,
                             input bit closes, input logic [31:0] idx, input bit with_gaps);
        word_req_t w;
        logic [63:0] folded;
        int unsigned gap;
        folded = rnd64();
        w.col_a = rnd64();
        w.col_b = rnd64();
        w.col_c = rnd64();
        w.col_d = w.col_a ^ w.col_b ^ w.col_c ^ folded;
        w.in_mask = folded ^ in_diff;
        w.out_mask = folded ^ out_diff;
        w.idx = idx;
        w.closes = closes;

        s_valid <= 1'b1;
        s_col_a_word <= w.col_a;
        s_col_b_word <= w.col_b;
        s_col_c_word <= w.col_c;
        s_col_d_word <= w.col_d;
        s_in_mask_word <= w.in_mask;
        s_out_mask_word <= w.out_mask;
        s_first_index <= w.idx[7:0];
        s_second_index <= w.idx[15:8];
        s_third_index <= w.idx[23:16];
        s_fourth_index <= w.idx[31:24];
        s_last_word <= w.closes;
        do @(posedge aclk); while (!s_ready);

        advance_walsh_stats(w);
        words_sent++;
        gap = with_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering words and waits until every owed result has come back,
    // then lets the block settle so that it is idle for a register write.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the sample count; callers make sure the block is idle first.
    task automatic write_sample_count(input logic [17:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_samples = n;
        cfg_writes++;
    endtask

    // The first tuple runs at the reset sample count of 131072. Every word
    // disagrees in every bit with both masks, so after 1024 words both
    // correlations are zero only if the reset value is right. With a zero
    // product no best tuple exists yet and its fields must read zero.
    task automatic test_reset_sample_count();
        for (int k = 0; k < RESET_CHECK_WORDS; k++) begin
            send_word('1, '1, k == RESET_CHECK_WORDS - 1, $urandom, 1'b0);
        end
        drain();
    endtask

    // Short hand-built tuples: zero product, first best, a tie, a multi-word
    // tuple, both threshold boundaries, and the smallest sample counts.
    task automatic test_directed();
        sink_jitter <= 1'b1;
        write_sample_count(18'd64);
        // Half the input bits disagree: c_in is zero, so still no best tuple.
        send_word(low_ones(32), '0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // Full agreement on both sides: c = 64 twice, the first real best.
        send_word('0, '0, 1'b1, 32'h55AA_00FF, 1'b1);
        // Opposite sign with the same magnitude ties and must not replace it.
        send_word('1, '0, 1'b1, 32'h0000_0000, 1'b1);
        // A three-word tuple with its indices taken from the closing word.
        send_word(low_ones(10), low_ones(3), 1'b0, 32'h0102_0304, 1'b1);
        send_word(low_ones(10), low_ones(60), 1'b0, 32'h0506_0708, 1'b1);
        send_word(low_ones(10), '0, 1'b1, 32'hF0E1_D2C3, 1'b1);
        // With N = 64 the bound for |z| > 2 is c*c > 256, i.e. c of 18 but
        // not 16. The bound for |z| > 3 is c*c > 576, i.e. c of 26 but not 24.
        send_word(low_ones(24), low_ones(23), 1'b1, $urandom, 1'b1);
        send_word(low_ones(23), low_ones(23), 1'b1, $urandom, 1'b1);
        send_word(low_ones(19), low_ones(20), 1'b1, $urandom, 1'b1);
        send_word(low_ones(19), low_ones(19), 1'b1, $urandom, 1'b1);
        drain();

        // N = 1: a perfect match gives c = 1, a full mismatch c = -127 and a
        // new best with two negative correlations.
        write_sample_count(18'd1);
        send_word('0, '0, 1'b1, $urandom, 1'b0);
        send_word('1, '1, 1'b1, $urandom, 1'b0);
        drain();

        // N = 0 is used as given: correlations can only be zero or negative.
        write_sample_count(18'd0);
        send_word('0, '0, 1'b1, $urandom, 1'b1);
        send_word('1, low_ones(1), 1'b1, $urandom, 1'b1);
        drain();
    endtask

    // Random tuples in phases of varying sample count, so the best tuple keeps
    // moving. Phases differ in whether the sender and the receiver idle.
    task automatic test_random();
        logic [17:0] phase_n [RANDOM_PHASES];
        int sent;
        int len;
        int unsigned r;
        lean_t lean_in;
        lean_t lean_out;
        bit with_gaps;
        phase_n = '{18'd64, 18'd100, 18'd128, 18'd256, 18'($urandom_range(1, 512)),
                    18'd1024, 18'($urandom_range(1, xpcs_pkg::CORR_LIMIT)),
                    18'(xpcs_pkg::SAMPLE_COUNT_RESET)};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_sample_count(phase_n[p]);
            sink_jitter <= (p % 3 != 1);
            with_gaps = (p % 3 != 2);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                r = $urandom_range(0, 19);
                if (r < 14) len = $urandom_range(1, 4);
                else if (r < 19) len = $urandom_range(5, 16);
                else len = $urandom_range(17, 40);
                lean_in = lean_t'($urandom_range(0, 2));
                lean_out = lean_t'($urandom_range(0, 2));
                for (int k = 0; k < len; k++) begin
                    send_word(lean_diff(lean_in), lean_diff(lean_out), k == len - 1,
                              $urandom, with_gaps);
                end
                sent += len;
            end
            drain();
        end
    endtask

    // A sample count above the correlation range pushes N - 2*pop past the
    // upper clamp on both sides, with and without disagreeing bits.
    task automatic test_correlation_clamp();
        write_sample_count(18'h3FFFF);
        send_word('0, '0, 1'b1, 32'hFF00_FF00, 1'b1);
        send_word(low_ones(64), low_ones(5), 1'b1, 32'h00FF_00FF, 1'b1);
        drain();
    endtask

    // The receiver holds off for a long stretch while one-word tuples keep
    // coming, so the tuple queue fills and the block stops taking words.
    task automatic test_backpressure();
        write_sample_count(18'(xpcs_pkg::SAMPLE_COUNT_RESET));
        sink_jitter <= 1'b0;
        -> hold_kick;
        for (int k = 0; k < PRESSURE_TUPLES; k++) begin
            send_word(lean_diff(LEAN_AGREE), lean_diff(LEAN_NONE), 1'b1, $urandom, 1'b0);
        end
        drain();
    endtask

    // Result receiver. Outside the hold-off window it is ready by default and,
    // when jitter is on, now and then drops ready for a random gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_active) begin
            m_ready <= 1'b0;
        end else if (sink_wait != 0) begin
            m_ready <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_ready <= 1'b1;
            if (sink_jitter && $urandom_range(0, 3) == 0) sink_wait <= pick_gap();
        end
    end

    // Hold-off window, counted here in cycles once a test asks for it.
    initial begin : sink_hold
        forever begin
            @(hold_kick);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_active <= 1'b0;
        end
    end

    task automatic compare_field(input string tag, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, tag, want, got);
            errors++;
        end
    endtask

    // Every accepted result request is matched against the oldest owed one.
    // Values are taken as they stood at the clock edge.
    always @(posedge aclk) begin : result_check
        stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stats_due.size() == 0) begin
                $display("%0t: unexpected result request: expected none, actual tuple_total %h",
                         $time, m_tuple_total);
                errors++;
            end else begin
                want = stats_due.pop_front();
                compare_field("product_total", want.product_total, $unsigned(m_product_total));
                compare_field("peak_abs_in", want.peak_in, m_peak_abs_in);
                compare_field("peak_abs_out", want.peak_out, m_peak_abs_out);
                compare_field("best_first", want.best_idx[7:0], m_best_first);
                compare_field("best_second", want.best_idx[15:8], m_best_second);
                compare_field("best_third", want.best_idx[23:16], m_best_third);
                compare_field("best_fourth", want.best_idx[31:24], m_best_fourth);
                compare_field("best_corr_in", want.corr_in, $unsigned(m_best_corr_in));
                compare_field("best_corr_out", want.corr_out, $unsigned(m_best_corr_out));
                compare_field("both_over_two", want.over_two, m_both_over_two);
                compare_field("both_over_three", want.over_three, m_both_over_three);
                compare_field("tuple_total", want.tuples, m_tuple_total);
                results_seen++;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still owed", $time, stats_due.size());
            $display("xor_popcount_walsh_chain_stats_tb: FAIL");
            $finish;
        end
    end

    // Reset once, run the tests in turn, then report.
    initial begin : run
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_sample_count();
        test_directed();
        test_random();
        test_correlation_clamp();
        test_backpressure();
        drain();

        $display("Sent %0d word requests over %0d sample count settings; %0d tuple results checked.",
                 words_sent, cfg_writes, results_seen);
        $display("Covered threshold edges, ties, upper clamping and a full queue stall.");
        if (errors == 0) begin
            $display("xor_popcount_walsh_chain_stats_tb: PASS");
        end else begin
            $display("xor_popcount_walsh_chain_stats_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
